FILE: design/clhd_pkg.sv
package clhd_pkg;

    // width of the length accumulator and body counter
    localparam int LENGTH_BITS = 32;
    // width of the reported length field
    localparam int LEN_OUT_BITS = 32;
    // guard bits for the times-ten overflow check
    localparam int GUARD_BITS = 4;
    localparam int MI_BITS = 4;

    // literal lengths
    localparam logic [MI_BITS-1:0] PREFIX_LEN = MI_BITS'(8);
    localparam logic [MI_BITS-1:0] LENGTH_LEN = MI_BITS'(6);
    localparam logic [MI_BITS-1:0] TYPE_LEN   = MI_BITS'(4);
    localparam logic [MI_BITS-1:0] SEP_LEN    = MI_BITS'(2);

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [MI_BITS-1:0] t_match_idx;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_TYPE   = 3'd1,
        KIND_DONE   = 3'd2,
        KIND_BODY   = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_PREFIX   = 3'd1,
        ERR_NAME     = 3'd2,
        ERR_DUP_TYPE = 3'd3,
        ERR_SEP      = 3'd4,
        ERR_NUMBER   = 3'd5,
        ERR_LINE_END = 3'd6
    } t_err;

    typedef enum logic [11:0] {
        PH_LINE      = 12'b0000_0000_0001,
        PH_PREFIX    = 12'b0000_0000_0010,
        PH_CHOICE    = 12'b0000_0000_0100,
        PH_NAME_LEN  = 12'b0000_0000_1000,
        PH_NAME_TYPE = 12'b0000_0001_0000,
        PH_SEP_LEN   = 12'b0000_0010_0000,
        PH_SEP_TYPE  = 12'b0000_0100_0000,
        PH_NUMBER    = 12'b0000_1000_0000,
        PH_TYPE_TEXT = 12'b0001_0000_0000,
        PH_LINE_LF   = 12'b0010_0000_0000,
        PH_END_LF    = 12'b0100_0000_0000,
        PH_BODY      = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              data;
        logic [LEN_OUT_BITS-1:0] length;
        t_err                    fault_code;
        logic                    last;
    } t_result;

    // "Content-"
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h43;
            3'd1:    c = 8'h6F;
            3'd2:    c = 8'h6E;
            3'd3:    c = 8'h74;
            3'd4:    c = 8'h65;
            3'd5:    c = 8'h6E;
            3'd6:    c = 8'h74;
            default: c = 8'h2D;
        endcase
        return c;
    endfunction

    // "Length"
    function automatic logic [7:0] length_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h4C;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h6E;
            3'd3:    c = 8'h67;
            3'd4:    c = 8'h74;
            3'd5:    c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Type"
    function automatic logic [7:0] type_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h54;
            2'd1:    c = 8'h79;
            2'd2:    c = 8'h70;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    // ": "
    function automatic logic [7:0] sep_char(input logic idx);
        return idx ? 8'h20 : 8'h3A;
    endfunction

endpackage

FILE: design/clhd_ifs.sv
interface clhd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface clhd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] length;
    logic [2:0]  fault_code;
    logic        last;

    modport source (
        output valid, output kind, output data, output length,
        output fault_code, output last, input ready
    );
    modport sink (
        input valid, input kind, input data, input length,
        input fault_code, input last, output ready
    );
endinterface

FILE: design/clhd_parser.sv
module clhd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    output clhd_pkg::t_result  o_res
);

    clhd_pkg::t_phase     r_phase, n_phase;
    clhd_pkg::t_match_idx r_mi, n_mi;
    clhd_pkg::t_len       r_acc, n_acc;
    logic                 r_digits, n_digits;
    logic                 r_type_seen, n_type_seen;
    clhd_pkg::t_len       r_rem, n_rem;
    clhd_pkg::t_err       r_err, n_err;

    clhd_pkg::t_match_idx mi_inc;
    clhd_pkg::t_len       rem_dec;
    logic [clhd_pkg::LENGTH_BITS+clhd_pkg::GUARD_BITS-1:0] acc_wide, acc_next;
    logic                 is_digit;
    logic                 overflow;
    clhd_pkg::t_err       err;
    clhd_pkg::t_kind      kind;
    logic [7:0]           data;
    logic [clhd_pkg::LEN_OUT_BITS-1:0] len;
    logic                 last;

    assign mi_inc   = r_mi + clhd_pkg::MI_BITS'(1);
    assign rem_dec  = (r_rem != '0) ? r_rem - clhd_pkg::LENGTH_BITS'(1) : r_rem;
    assign is_digit = (i_byte >= clhd_pkg::CH_ZERO) && (i_byte <= clhd_pkg::CH_NINE);
    // acc * 10 + digit, with guard bits to catch a carry past the top
    assign acc_wide = {{clhd_pkg::GUARD_BITS{1'b0}}, r_acc};
    assign acc_next = (acc_wide << 3) + (acc_wide << 1)
                    + {{(clhd_pkg::LENGTH_BITS){1'b0}}, i_byte[3:0]};
    assign overflow = |acc_next[clhd_pkg::LENGTH_BITS+clhd_pkg::GUARD_BITS-1:
                                clhd_pkg::LENGTH_BITS];

    always_comb begin
        n_phase     = r_phase;
        n_mi        = r_mi;
        n_acc       = r_acc;
        n_digits    = r_digits;
        n_type_seen = r_type_seen;
        n_rem       = r_rem;
        n_err       = r_err;
        err         = clhd_pkg::ERR_NONE;
        kind        = clhd_pkg::KIND_HEADER;
        data        = 8'h00;
        len         = '0;
        last        = 1'b0;
        if (r_err != clhd_pkg::ERR_NONE) begin
            err = r_err;
        end else begin
            unique case (r_phase)
                clhd_pkg::PH_LINE: begin
                    if (i_byte == clhd_pkg::CH_CR) begin
                        n_phase = clhd_pkg::PH_END_LF;
                    end else if (i_byte == clhd_pkg::CH_C) begin
                        n_phase = clhd_pkg::PH_PREFIX;
                        n_mi    = clhd_pkg::MI_BITS'(1);
                    end else begin
                        err = clhd_pkg::ERR_PREFIX;
                    end
                end
                clhd_pkg::PH_PREFIX: begin
                    if (r_mi < clhd_pkg::PREFIX_LEN
                        && i_byte == clhd_pkg::prefix_char(r_mi[2:0])) begin
                        n_mi = mi_inc;
                        if (mi_inc == clhd_pkg::PREFIX_LEN) n_phase = clhd_pkg::PH_CHOICE;
                    end else begin
                        err = clhd_pkg::ERR_PREFIX;
                    end
                end
                clhd_pkg::PH_CHOICE: begin
                    if (i_byte == clhd_pkg::CH_L) begin
                        n_phase = clhd_pkg::PH_NAME_LEN;
                        n_mi    = clhd_pkg::MI_BITS'(1);
                    end else if (i_byte == clhd_pkg::CH_T) begin
                        if (r_type_seen) begin
                            err = clhd_pkg::ERR_DUP_TYPE;
                        end else begin
                            n_phase = clhd_pkg::PH_NAME_TYPE;
                            n_mi    = clhd_pkg::MI_BITS'(1);
                        end
                    end else begin
                        err = clhd_pkg::ERR_NAME;
                    end
                end
                clhd_pkg::PH_NAME_LEN: begin
                    if (r_mi < clhd_pkg::LENGTH_LEN
                        && i_byte == clhd_pkg::length_char(r_mi[2:0])) begin
                        n_mi = mi_inc;
                        if (mi_inc == clhd_pkg::LENGTH_LEN) begin
                            n_phase = clhd_pkg::PH_SEP_LEN;
                            n_mi    = '0;
                        end
                    end else begin
                        err = clhd_pkg::ERR_NAME;
                    end
                end
                clhd_pkg::PH_NAME_TYPE: begin
                    if (r_mi < clhd_pkg::TYPE_LEN
                        && i_byte == clhd_pkg::type_char(r_mi[1:0])) begin
                        n_mi = mi_inc;
                        if (mi_inc == clhd_pkg::TYPE_LEN) begin
                            n_phase = clhd_pkg::PH_SEP_TYPE;
                            n_mi    = '0;
                        end
                    end else begin
                        err = clhd_pkg::ERR_NAME;
                    end
                end
                clhd_pkg::PH_SEP_LEN, clhd_pkg::PH_SEP_TYPE: begin
                    if (r_mi < clhd_pkg::SEP_LEN
                        && i_byte == clhd_pkg::sep_char(r_mi[0])) begin
                        n_mi = mi_inc;
                        if (mi_inc == clhd_pkg::SEP_LEN) begin
                            n_mi = '0;
                            if (r_phase == clhd_pkg::PH_SEP_LEN) begin
                                n_phase  = clhd_pkg::PH_NUMBER;
                                n_acc    = '0;
                                n_digits = 1'b0;
                            end else begin
                                n_phase = clhd_pkg::PH_TYPE_TEXT;
                            end
                        end
                    end else begin
                        err = clhd_pkg::ERR_SEP;
                    end
                end
                clhd_pkg::PH_NUMBER: begin
                    if (is_digit) begin
                        if (overflow) begin
                            err = clhd_pkg::ERR_NUMBER;
                        end else begin
                            n_acc    = acc_next[clhd_pkg::LENGTH_BITS-1:0];
                            n_digits = 1'b1;
                        end
                    end else if (!r_digits) begin
                        // leading blanks are skipped
                        if (i_byte != clhd_pkg::CH_SPACE && i_byte != clhd_pkg::CH_TAB)
                            err = clhd_pkg::ERR_NUMBER;
                    end else if (i_byte == clhd_pkg::CH_CR) begin
                        n_phase = clhd_pkg::PH_LINE_LF;
                    end else begin
                        err = clhd_pkg::ERR_LINE_END;
                    end
                end
                clhd_pkg::PH_TYPE_TEXT: begin
                    if (i_byte == clhd_pkg::CH_CR) begin
                        n_phase = clhd_pkg::PH_LINE_LF;
                    end else begin
                        kind        = clhd_pkg::KIND_TYPE;
                        data        = i_byte;
                        n_type_seen = 1'b1;
                    end
                end
                clhd_pkg::PH_LINE_LF: begin
                    if (i_byte == clhd_pkg::CH_LF) n_phase = clhd_pkg::PH_LINE;
                    else err = clhd_pkg::ERR_LINE_END;
                end
                clhd_pkg::PH_END_LF: begin
                    if (i_byte == clhd_pkg::CH_LF) begin
                        kind = clhd_pkg::KIND_DONE;
                        len  = clhd_pkg::LEN_OUT_BITS'(r_acc);
                        if (r_acc == '0) begin
                            last    = 1'b1;
                            n_phase = clhd_pkg::PH_LINE;
                        end else begin
                            n_rem   = r_acc;
                            n_phase = clhd_pkg::PH_BODY;
                        end
                        n_mi        = '0;
                        n_acc       = '0;
                        n_digits    = 1'b0;
                        n_type_seen = 1'b0;
                    end else begin
                        err = clhd_pkg::ERR_LINE_END;
                    end
                end
                clhd_pkg::PH_BODY: begin
                    kind  = clhd_pkg::KIND_BODY;
                    data  = i_byte;
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        last    = 1'b1;
                        n_phase = clhd_pkg::PH_LINE;
                    end
                end
                default: begin
                    n_phase = clhd_pkg::PH_LINE;
                end
            endcase
            n_err = err;
        end
    end

    always_comb begin
        o_res.kind       = kind;
        o_res.data       = data;
        o_res.length     = len;
        o_res.fault_code = err;
        o_res.last       = last;
        if (err != clhd_pkg::ERR_NONE) begin
            o_res.kind   = clhd_pkg::KIND_ERROR;
            o_res.data   = 8'h00;
            o_res.length = '0;
            o_res.last   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= clhd_pkg::PH_LINE;
            r_mi        <= '0;
            r_acc       <= '0;
            r_digits    <= 1'b0;
            r_type_seen <= 1'b0;
            r_rem       <= '0;
            r_err       <= clhd_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_mi        <= n_mi;
            r_acc       <= n_acc;
            r_digits    <= n_digits;
            r_type_seen <= n_type_seen;
            r_rem       <= n_rem;
            r_err       <= n_err;
        end
    end

endmodule

FILE: design/content_length_header_deframer.sv
// an accepted byte is held in the input register, then its parser result is captured in the result register
// throughput: one byte per cycle while the sink takes results; a stalled sink
// holds the result register, and the input stops once the input register is full
// the input register can take a new byte whenever it is empty or moves on
// reset (i_rst_n low, synchronous) empties both registers, returns the parser to
// the start of a header line and clears the sticky error
module content_length_header_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    clhd_byte_if.sink          i_in,
    clhd_result_if.source      o_out
);

    // input stage
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    // result stage
    logic              r_out_valid;
    clhd_pkg::t_result r_out;

    clhd_pkg::t_result step_res;
    logic              advance;

    // the held byte moves into the result register when that register is
    // free or is being emptied by the sink in this cycle
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // parser state is committed only on the cycle its result is captured,
    // so a stall never repeats or drops a step
    clhd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    // result port
    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.data       = r_out.data;
    assign o_out.length     = r_out.length;
    assign o_out.fault_code = r_out.fault_code;
    assign o_out.last       = r_out.last;

`ifndef NO_ASSERTIONS
    // error kind and error code go together
    a_err_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.kind == clhd_pkg::KIND_ERROR)
                         == (r_out.fault_code != clhd_pkg::ERR_NONE)))
        else $error("error kind and error code disagree");

    // last only marks a body byte or a header done
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.kind == clhd_pkg::KIND_BODY
                                         || r_out.kind == clhd_pkg::KIND_DONE))
        else $error("last flag on a result that is not body or header done");

    // a length appears only with header done
    a_length_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.length != '0) |-> (r_out.kind == clhd_pkg::KIND_DONE))
        else $error("length reported outside header done");

    // once an error result is followed by another step, that one is an error too
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == clhd_pkg::KIND_ERROR && advance)
        |=> (r_out.kind == clhd_pkg::KIND_ERROR))
        else $error("error did not stay set");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // clock, reset and the two channels
    logic i_clk = 1'b0;
    logic i_rst_n;

    clhd_byte_if   byte_ch();
    clhd_result_if result_ch();

    content_length_header_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // header literals, right-aligned, first character in the highest used byte
    localparam logic [63:0] PREFIX_TXT = "Content-";
    localparam logic [63:0] LENGTH_TXT = "Length";
    localparam logic [63:0] TYPE_TXT   = "Type";
    localparam logic [63:0] SEP_TXT    = ": ";

    // results that can be read straight off the header grammar
    localparam clhd_pkg::t_result R_HEADER =
        {clhd_pkg::KIND_HEADER, 8'h00, 32'd0, clhd_pkg::ERR_NONE, 1'b0};
    localparam clhd_pkg::t_result R_DONE_EMPTY =
        {clhd_pkg::KIND_DONE, 8'h00, 32'd0, clhd_pkg::ERR_NONE, 1'b1};
    localparam clhd_pkg::t_result R_TYPE_00 =
        {clhd_pkg::KIND_TYPE, 8'h00, 32'd0, clhd_pkg::ERR_NONE, 1'b0};
    localparam clhd_pkg::t_result R_TYPE_FF =
        {clhd_pkg::KIND_TYPE, 8'hFF, 32'd0, clhd_pkg::ERR_NONE, 1'b0};
    localparam clhd_pkg::t_result R_UNTYPED = '0;

    typedef struct packed {
        logic [7:0]        b;
        logic              typed;
        clhd_pkg::t_result r;
    } t_step_row;

    // directed rows: empty header, type text holding the byte extremes, empty header again
    t_step_row dir_rows [22] = '{
        '{clhd_pkg::CH_CR, 1'b1, R_HEADER},
        '{clhd_pkg::CH_LF, 1'b1, R_DONE_EMPTY},
        '{"C", 1'b0, R_UNTYPED}, '{"o", 1'b0, R_UNTYPED}, '{"n", 1'b0, R_UNTYPED},
        '{"t", 1'b0, R_UNTYPED}, '{"e", 1'b0, R_UNTYPED}, '{"n", 1'b0, R_UNTYPED},
        '{"t", 1'b0, R_UNTYPED}, '{"-", 1'b0, R_UNTYPED}, '{"T", 1'b0, R_UNTYPED},
        '{"y", 1'b0, R_UNTYPED}, '{"p", 1'b0, R_UNTYPED}, '{"e", 1'b0, R_UNTYPED},
        '{":", 1'b0, R_UNTYPED}, '{" ", 1'b0, R_UNTYPED},
        '{8'h00, 1'b1, R_TYPE_00},
        '{8'hFF, 1'b1, R_TYPE_FF},
        '{clhd_pkg::CH_CR, 1'b0, R_UNTYPED},
        '{clhd_pkg::CH_LF, 1'b0, R_UNTYPED},
        '{clhd_pkg::CH_CR, 1'b1, R_HEADER},
        '{clhd_pkg::CH_LF, 1'b1, R_DONE_EMPTY}
    };

    // parser state as the testbench sees it
    clhd_pkg::t_phase     ph;
    clhd_pkg::t_match_idx mi;
    clhd_pkg::t_len       acc;
    bit                   digits;
    bit                   typed_text;
    clhd_pkg::t_len       remaining;
    clhd_pkg::t_err       sticky;

    // results owed by the block, oldest first
    clhd_pkg::t_result events_due [$];
    logic [7:0]        burst_q [$];
    int                mismatches = 0;
    int                bytes_sent = 0;
    bit                src_calm = 1'b0;

    function automatic logic [7:0] lit_char(input logic [63:0] txt, input int n, input int i);
        return txt[8*(n-1-i) +: 8];
    endfunction

    // one byte through the header state machine, returns the result it causes
    function automatic clhd_pkg::t_result deframe_byte(input logic [7:0] b);
        clhd_pkg::t_result r;
        clhd_pkg::t_err    e;
        logic [63:0]       grown;
        r = R_HEADER;
        e = clhd_pkg::ERR_NONE;
        if (sticky != clhd_pkg::ERR_NONE) begin
            e = sticky;
        end else begin
            case (ph)
                clhd_pkg::PH_PREFIX: begin
                    if (mi < clhd_pkg::PREFIX_LEN
                        && b == lit_char(PREFIX_TXT, 8, int'(mi))) begin
                        mi = mi + 1'b1;
                        if (mi == clhd_pkg::PREFIX_LEN) ph = clhd_pkg::PH_CHOICE;
                    end else begin
                        e = clhd_pkg::ERR_PREFIX;
                    end
                end
                clhd_pkg::PH_CHOICE: begin
                    if (b == clhd_pkg::CH_L) begin
                        ph = clhd_pkg::PH_NAME_LEN;
                        mi = clhd_pkg::MI_BITS'(1);
                    end else if (b == clhd_pkg::CH_T) begin
                        // a second type line after a non-empty one is refused on its first letter
                        if (typed_text) begin
                            e = clhd_pkg::ERR_DUP_TYPE;
                        end else begin
                            ph = clhd_pkg::PH_NAME_TYPE;
                            mi = clhd_pkg::MI_BITS'(1);
                        end
                    end else begin
                        e = clhd_pkg::ERR_NAME;
                    end
                end
                clhd_pkg::PH_NAME_LEN: begin
                    if (mi < clhd_pkg::LENGTH_LEN
                        && b == lit_char(LENGTH_TXT, 6, int'(mi))) begin
                        mi = mi + 1'b1;
                        if (mi == clhd_pkg::LENGTH_LEN) begin
                            ph = clhd_pkg::PH_SEP_LEN;
                            mi = '0;
                        end
                    end else begin
                        e = clhd_pkg::ERR_NAME;
                    end
                end
                clhd_pkg::PH_NAME_TYPE: begin
                    if (mi < clhd_pkg::TYPE_LEN
                        && b == lit_char(TYPE_TXT, 4, int'(mi))) begin
                        mi = mi + 1'b1;
                        if (mi == clhd_pkg::TYPE_LEN) begin
                            ph = clhd_pkg::PH_SEP_TYPE;
                            mi = '0;
                        end
                    end else begin
                        e = clhd_pkg::ERR_NAME;
                    end
                end
                clhd_pkg::PH_SEP_LEN, clhd_pkg::PH_SEP_TYPE: begin
                    if (mi < clhd_pkg::SEP_LEN
                        && b == lit_char(SEP_TXT, 2, int'(mi))) begin
                        mi = mi + 1'b1;
                        if (mi == clhd_pkg::SEP_LEN) begin
                            mi = '0;
                            if (ph == clhd_pkg::PH_SEP_LEN) begin
                                ph = clhd_pkg::PH_NUMBER;
                                acc = '0;
                                digits = 1'b0;
                            end else begin
                                ph = clhd_pkg::PH_TYPE_TEXT;
                            end
                        end
                    end else begin
                        e = clhd_pkg::ERR_SEP;
                    end
                end
                clhd_pkg::PH_NUMBER: begin
                    if (b >= clhd_pkg::CH_ZERO && b <= clhd_pkg::CH_NINE) begin
                        // any carry out of the accumulator width is an overflow
                        grown = 64'(acc) * 64'd10 + 64'(b - clhd_pkg::CH_ZERO);
                        if ((grown >> clhd_pkg::LENGTH_BITS) != 0) begin
                            e = clhd_pkg::ERR_NUMBER;
                        end else begin
                            acc = clhd_pkg::LENGTH_BITS'(grown);
                            digits = 1'b1;
                        end
                    end else if (!digits) begin
                        if (b != clhd_pkg::CH_SPACE && b != clhd_pkg::CH_TAB)
                            e = clhd_pkg::ERR_NUMBER;
                    end else if (b == clhd_pkg::CH_CR) begin
                        ph = clhd_pkg::PH_LINE_LF;
                    end else begin
                        e = clhd_pkg::ERR_LINE_END;
                    end
                end
                clhd_pkg::PH_TYPE_TEXT: begin
                    if (b == clhd_pkg::CH_CR) begin
                        ph = clhd_pkg::PH_LINE_LF;
                    end else begin
                        r.kind = clhd_pkg::KIND_TYPE;
                        r.data = b;
                        typed_text = 1'b1;
                    end
                end
                clhd_pkg::PH_LINE_LF: begin
                    if (b == clhd_pkg::CH_LF) ph = clhd_pkg::PH_LINE;
                    else e = clhd_pkg::ERR_LINE_END;
                end
                clhd_pkg::PH_END_LF: begin
                    if (b == clhd_pkg::CH_LF) begin
                        r.kind = clhd_pkg::KIND_DONE;
                        r.length = clhd_pkg::LEN_OUT_BITS'(acc);
                        if (acc == '0) begin
                            r.last = 1'b1;
                            ph = clhd_pkg::PH_LINE;
                        end else begin
                            remaining = acc;
                            ph = clhd_pkg::PH_BODY;
                        end
                        mi = '0;
                        acc = '0;
                        digits = 1'b0;
                        typed_text = 1'b0;
                    end else begin
                        e = clhd_pkg::ERR_LINE_END;
                    end
                end
                clhd_pkg::PH_BODY: begin
                    r.kind = clhd_pkg::KIND_BODY;
                    r.data = b;
                    if (remaining != '0) remaining = remaining - 1'b1;
                    if (remaining == '0) begin
                        r.last = 1'b1;
                        ph = clhd_pkg::PH_LINE;
                    end
                end
                default: begin
                    // start of a header line
                    if (b == clhd_pkg::CH_CR) begin
                        ph = clhd_pkg::PH_END_LF;
                    end else if (b == clhd_pkg::CH_C) begin
                        ph = clhd_pkg::PH_PREFIX;
                        mi = clhd_pkg::MI_BITS'(1);
                    end else begin
                        e = clhd_pkg::ERR_PREFIX;
                    end
                end
            endcase
            sticky = e;
        end
        if (e != clhd_pkg::ERR_NONE) r = {clhd_pkg::KIND_ERROR, 8'h00, 32'd0, e, 1'b0};
        return r;
    endfunction

    // offer one byte until it is taken, then record the result it owes
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input clhd_pkg::t_result r);
        clhd_pkg::t_result owed;
        while (!src_calm && $urandom_range(99) < 24) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        // transfer happened at this edge
        owed = deframe_byte(b);
        events_due.push_back(typed ? r : owed);
        bytes_sent++;
    endtask

    task automatic send_burst();
        foreach (burst_q[i]) send_byte(burst_q[i], 1'b0, R_UNTYPED);
        burst_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) burst_q.push_back(s[i]);
    endtask

    task automatic push_crlf();
        burst_q.push_back(clhd_pkg::CH_CR);
        burst_q.push_back(clhd_pkg::CH_LF);
    endtask

    // a length line, optionally with blanks and leading zeros before the digits
    task automatic push_length(input int unsigned v, input bit zeros);
        push_text("Content-Length: ");
        repeat ($urandom_range(0, 2))
            burst_q.push_back($urandom_range(0, 1) ? clhd_pkg::CH_SPACE : clhd_pkg::CH_TAB);
        if (zeros) push_text("00");
        push_text($sformatf("%0d", v));
    endtask

    // a well-formed message: up to three header entries (a huge length adds a line), blank line, then the body
    task automatic build_message();
        int          lines;
        int          n;
        int unsigned v;
        bit          type_done;
        int unsigned body_len;
        logic [7:0]  c;
        lines = $urandom_range(0, 3);
        type_done = 1'b0;
        body_len = 0;
        for (int i = 0; i < lines; i++) begin
            if (!type_done && $urandom_range(0, 2) == 0) begin
                // type text may hold any byte but CR, an empty one does not count
                push_text("Content-Type: ");
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    do c = 8'($urandom_range(0, 255)); while (c == clhd_pkg::CH_CR);
                    burst_q.push_back(c);
                end
                type_done = (n != 0);
            end else begin
                case ($urandom_range(0, 9))
                    0: v = 0;
                    9: begin
                        // a huge length, overridden by a later line
                        push_length($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom(), 1'b0);
                        push_crlf();
                        v = $urandom_range(1, 12);
                    end
                    default: v = $urandom_range(1, 12);
                endcase
                push_length(v, $urandom_range(0, 3) == 0);
                body_len = v;
            end
            push_crlf();
        end
        push_crlf();
        repeat (body_len) burst_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // errors are sticky until reset, so one kind of fault closes each run
    task automatic build_error_tail();
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0: begin
                do c = 8'($urandom_range(0, 255));
                while (c == clhd_pkg::CH_C || c == clhd_pkg::CH_CR);
                burst_q.push_back(c);
            end
            1: push_text("Conx");
            2: push_text("Content-Q");
            3: begin
                push_text("Content-Type: ab");
                push_crlf();
                push_text("Content-T");
            end
            4: push_text("Content-Length;");
            5: begin
                if ($urandom_range(0, 1)) push_text("Content-Length: 4294967296");
                else push_text("Content-Length: x");
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    push_text("Content-Length: 7x");
                end else begin
                    burst_q.push_back(clhd_pkg::CH_CR);
                    burst_q.push_back(8'h41);
                end
            end
        endcase
        repeat (8) burst_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: compare each transfer with the oldest owed result
    always @(posedge i_clk) begin
        clhd_pkg::t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (events_due.size() == 0) begin
                $error("result with nothing owed: kind %0d data %0d",
                       result_ch.kind, result_ch.data);
                mismatches++;
            end else begin
                want = events_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(result_ch.kind));
                check_field("data", 32'(want.data), 32'(result_ch.data));
                check_field("length", 32'(want.length), 32'(result_ch.length));
                check_field("fault_code", 32'(want.fault_code), 32'(result_ch.fault_code));
                check_field("last", 32'(want.last), 32'(result_ch.last));
            end
        end
    end

    // receiver: random back-pressure, a calm window and one long hold-off
    initial begin
        int cyc;
        cyc = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 600) begin
                // block fills up while the sender keeps offering
                result_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end else if (cyc >= 900 && cyc < 1400) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= 24);
            end
        end
    end

    // stimulus and end of run
    initial begin
        int msg_no;
        i_rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.byte_in <= 8'h00;
        ph = clhd_pkg::PH_LINE;
        mi = '0;
        acc = '0;
        digits = 1'b0;
        typed_text = 1'b0;
        remaining = '0;
        sticky = clhd_pkg::ERR_NONE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].r);

        msg_no = 0;
        while (bytes_sent < 1150) begin
            // once the sender waits for everything owed before carrying on
            if (msg_no == 6) drain();
            src_calm = (msg_no >= 12 && msg_no < 20);
            build_message();
            send_burst();
            msg_no++;
        end
        src_calm = 1'b0;
        build_error_tail();
        send_burst();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
